@@ sv/cfc_pkg.sv @@
// Shared types, constants and helpers for the coordinate frame converter.
package cfc_pkg;

  localparam int CW   = 45;
  localparam int RW   = 34;
  localparam int PW   = 36;
  localparam int SATW = 40;

  localparam logic [1:0] REQ_CART = 2'd0;
  localparam logic [1:0] REQ_SPH  = 2'd1;
  localparam logic [1:0] REQ_CYL  = 2'd2;

  localparam logic signed [21:0]   INV_GAIN_Q20 = 22'sd636751;
  localparam logic signed [RW-1:0] INV_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [SATW-1:0] S32_MAX = 40'sh00_7fff_ffff;
  localparam logic signed [SATW-1:0] S32_MIN = 40'shff_8000_0000;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85005780, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat32_t;

  typedef struct packed {
    logic        ovf;
    logic [30:0] val;
  } sat31_t;

  typedef struct packed {
    logic [1:0]         req;
    logic signed [31:0] da;
    logic signed [31:0] db;
    logic signed [31:0] dc;
    logic [15:0]        th;
    logic [15:0]        ph;
    logic               nz;
  } side1_t;

  typedef struct packed {
    logic [1:0]           req;
    logic signed [31:0]   da;
    logic signed [31:0]   db;
    logic signed [31:0]   dc;
    logic [15:0]          th;
    logic [15:0]          ph;
    logic [15:0]          az;
    logic signed [CW-1:0] rhog;
    logic signed [33:0]   ah;
    logic signed [PW-1:0] rho;
    logic signed [PW-1:0] oz;
    logic signed [PW-1:0] mx;
    logic signed [PW-1:0] my;
    logic                 zero;
  } side2_t;

  function automatic sat32_t sat_s32(input logic signed [SATW-1:0] v);
    sat32_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > S32_MAX) begin
      r.ovf = 1'b1;
      r.val = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r.ovf = 1'b1;
      r.val = S32_MIN[31:0];
    end
    return r;
  endfunction

  function automatic sat31_t sat_u31(input logic signed [SATW-1:0] v);
    sat31_t r;
    r.ovf = 1'b0;
    r.val = v[30:0];
    if (v > S32_MAX) begin
      r.ovf = 1'b1;
      r.val = S32_MAX[30:0];
    end else if (v[SATW-1]) begin
      r.ovf = 1'b1;
      r.val = '0;
    end
    return r;
  endfunction

  // Round half up, drop 30 fraction bits.
  function automatic logic signed [PW-1:0] rnd30(input logic signed [69:0] p);
    logic signed [69:0] t;
    t = p + 70'sd536870912;
    return t[65:30];
  endfunction

endpackage

@@ sv/coordinate_frame_converter.sv @@
// Throughput: one point per cycle while the output is not stalled; two CORDIC pipelines in series set the depth.
// The whole pipeline holds while the output register is stalled.
// Reset clears all valid bits; data registers are not reset.
// Top level: coordinate frame converter.
module coordinate_frame_converter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] dist_a_i,
  input  logic signed [31:0] dist_b_i,
  input  logic signed [31:0] dist_c_i,
  input  logic [15:0]        angle_a_i,
  input  logic [15:0]        angle_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [30:0]        out_radius_o,
  output logic [15:0]        out_polar_o,
  output logic [15:0]        out_azimuth_o,
  output logic signed [31:0] out_rho_o,
  output logic               overflow_o
);
  import cfc_pkg::*;

  logic en;
  logic [15:0] th_c, ph_c;
  side1_t side1_in, s1;
  side2_t side2_in, s2;
  logic [$bits(side1_t)-1:0] s1_bits;
  logic [$bits(side2_t)-1:0] s2_bits;
  logic signed [CW-1:0] vx1, vy1, mag1, mag2;
  logic [31:0] a1, a2;
  logic v1, v2;
  logic signed [RW-1:0] ct, st, cp, sp;

  logic p1_v_q, p2_v_q, out_v_q;
  side2_t p1_q, p2_d, p2_q;
  logic signed [RW-1:0] cp_q, sp_q;
  logic signed [PW-1:0] mx2_q, my2_q;
  logic signed [33:0] da34, ah;
  logic signed [CW-1:0] h2, v2in, h2_q, v2_q;

  assign en = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    th_c = angle_a_i;
    ph_c = angle_b_i;
    if (req_type_i == REQ_SPH) begin
      if (dist_a_i[31]) begin
        th_c = 16'd32768 - th_c;
        ph_c = ph_c + 16'd32768;
      end
      if (th_c > 16'd32768) begin
        th_c = 16'd0 - th_c;
        ph_c = ph_c + 16'd32768;
      end
    end
  end

  assign vx1 = {{(CW-40){dist_a_i[31]}}, dist_a_i, 8'd0};
  assign vy1 = {{(CW-40){dist_b_i[31]}}, dist_b_i, 8'd0};

  assign side1_in = '{req: req_type_i, da: dist_a_i, db: dist_b_i, dc: dist_c_i,
                      th: th_c, ph: ph_c, nz: (|dist_a_i) | (|dist_b_i)};

  cfc_vec #(.STEPS(CORDIC_STEPS), .SW($bits(side1_t))) u_vec_xy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .side_i(side1_in),
    .x_i(vx1), .y_i(vy1), .valid_o(v1), .side_o(s1_bits), .mag_o(mag1), .ang_o(a1)
  );

  cfc_rot #(.STEPS(CORDIC_STEPS)) u_rot_th (
    .clk_i, .en_i(en), .ang_i({th_c, 16'h0}), .cos_o(ct), .sin_o(st)
  );

  cfc_rot #(.STEPS(CORDIC_STEPS)) u_rot_ph (
    .clk_i, .en_i(en), .ang_i({ph_c, 16'h0}), .cos_o(cp), .sin_o(sp)
  );

  assign s1   = side1_t'(s1_bits);
  assign da34 = {{2{s1.da[31]}}, s1.da};
  assign ah   = s1.da[31] ? -da34 : da34;

  // Stage P1: first products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.req  <= s1.req;
      p1_q.da   <= s1.da;
      p1_q.db   <= s1.db;
      p1_q.dc   <= s1.dc;
      p1_q.th   <= s1.th;
      p1_q.ph   <= s1.ph;
      p1_q.az   <= s1.nz ? 16'((a1 + 32'h0000_8000) >> 16) : 16'd0;
      p1_q.rhog <= s1.nz ? mag1 : '0;
      p1_q.ah   <= ah;
      p1_q.rho  <= rnd30(70'(ah) * 70'(st));
      p1_q.oz   <= rnd30(70'(ah) * 70'(ct));
      p1_q.mx   <= '0;
      p1_q.my   <= '0;
      p1_q.zero <= 1'b0;
      mx2_q     <= rnd30(70'(da34) * 70'(cp));
      my2_q     <= rnd30(70'(da34) * 70'(sp));
      cp_q      <= cp;
      sp_q      <= sp;
    end
  end

  assign h2   = (p1_q.req == REQ_CART) ? p1_q.rhog
                                       : {{(CW-42){p1_q.ah[33]}}, p1_q.ah, 8'd0};
  assign v2in = {{(CW-40){p1_q.dc[31]}}, p1_q.dc, 8'd0};

  // Stage P2: second products, polar CORDIC operands.
  always_comb begin
    p2_d      = p1_q;
    p2_d.mx   = (p1_q.req == REQ_SPH) ? rnd30(70'(p1_q.rho) * 70'(cp_q)) : mx2_q;
    p2_d.my   = (p1_q.req == REQ_SPH) ? rnd30(70'(p1_q.rho) * 70'(sp_q)) : my2_q;
    p2_d.zero = (h2 == '0) && (v2in == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q <= p2_d;
      h2_q <= h2;
      v2_q <= v2in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= v1;
      p2_v_q <= p1_v_q;
    end
  end

  assign side2_in = p2_q;

  cfc_vec #(.STEPS(CORDIC_STEPS), .SW($bits(side2_t))) u_vec_rz (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p2_v_q), .side_i(side2_in),
    .x_i(h2_q), .y_i(v2_q), .valid_o(v2), .side_o(s2_bits), .mag_o(mag2), .ang_o(a2)
  );

  assign s2 = side2_t'(s2_bits);

  logic signed [31:0] ox_d, oy_d, oz_d, orho_d, ox_q, oy_q, oz_q, orho_q;
  logic [30:0] orad_d, orad_q;
  logic [15:0] pol_d, az_d, pol_q, az_q;
  logic ovf_d, ovf_q;

  always_comb begin
    logic signed [CW-1:0] rg, rgs, rhs;
    logic signed [33:0]   thp;
    logic [33:0]          thr;
    logic [15:0]          polc;
    sat32_t sx, sy, sz, sr;
    sat31_t sd;

    rg  = s2.zero ? '0 : mag2;
    rgs = rg + CW'(128);
    rhs = s2.rhog + CW'(128);
    thp = 34'sh0_4000_0000 - {{2{a2[31]}}, a2};
    if (thp[33]) begin
      thp = '0;
    end else if (thp > 34'sh0_8000_0000) begin
      thp = 34'sh0_8000_0000;
    end
    thr  = thp + 34'h0_0000_8000;
    polc = s2.zero ? 16'd0 : thr[31:16];

    sx = sat_s32({{(SATW-PW){s2.mx[PW-1]}}, s2.mx});
    sy = sat_s32({{(SATW-PW){s2.my[PW-1]}}, s2.my});
    sz = sat_s32({{(SATW-PW){s2.oz[PW-1]}}, s2.oz});
    sd = '0;
    sr = '0;

    ox_d = '0; oy_d = '0; oz_d = '0; orho_d = '0;
    orad_d = '0; pol_d = '0; az_d = '0; ovf_d = 1'b0;
    case (s2.req)
      REQ_CART: begin
        sd = sat_u31({{(SATW-CW+8){rgs[CW-1]}}, rgs[CW-1:8]});
        sr = sat_s32({{(SATW-CW+8){rhs[CW-1]}}, rhs[CW-1:8]});
        ox_d = s2.da; oy_d = s2.db; oz_d = s2.dc;
        orad_d = sd.val; orho_d = sr.val;
        pol_d = polc; az_d = s2.az;
        ovf_d = sd.ovf | sr.ovf;
      end
      REQ_SPH: begin
        sd = sat_u31({{(SATW-34){s2.ah[33]}}, s2.ah});
        sr = sat_s32({{(SATW-PW){s2.rho[PW-1]}}, s2.rho});
        ox_d = sx.val; oy_d = sy.val; oz_d = sz.val;
        orad_d = sd.val; orho_d = sr.val;
        pol_d = (s2.ah == '0) ? 16'd0 : s2.th;
        az_d = s2.ph;
        ovf_d = sx.ovf | sy.ovf | sz.ovf | sd.ovf | sr.ovf;
      end
      REQ_CYL: begin
        sd = sat_u31({{(SATW-CW+8){rgs[CW-1]}}, rgs[CW-1:8]});
        ox_d = sx.val; oy_d = sy.val; oz_d = s2.dc;
        orad_d = sd.val; orho_d = s2.da;
        pol_d = polc; az_d = s2.ph;
        ovf_d = sx.ovf | sy.ovf | sd.ovf;
      end
      default: begin
        ovf_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      oz_q   <= oz_d;
      orad_q <= orad_d;
      pol_q  <= pol_d;
      az_q   <= az_d;
      orho_q <= orho_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v2;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_z_o       = oz_q;
  assign out_radius_o  = orad_q;
  assign out_polar_o   = pol_q;
  assign out_azimuth_o = az_q;
  assign out_rho_o     = orho_q;
  assign overflow_o    = ovf_q;

`ifndef SYNTHESIS
  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_polar_o <= 16'd32768)
    else $error("polar angle above half turn");

  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (out_x_o == 32'sh7fff_ffff || out_x_o == 32'sh8000_0000 ||
       out_y_o == 32'sh7fff_ffff || out_y_o == 32'sh8000_0000 ||
       out_z_o == 32'sh7fff_ffff || out_z_o == 32'sh8000_0000 ||
       out_rho_o == 32'sh7fff_ffff || out_rho_o == 32'sh8000_0000 ||
       out_radius_o == 31'h7fff_ffff || out_radius_o == 31'h0))
    else $error("overflow without a saturated field");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(p1_v_q) && $stable(p2_v_q)))
    else $error("pipeline advanced under stall");
`endif

endmodule

@@ sv/cfc_vec.sv @@
// Pipelined vectoring CORDIC: gain-corrected magnitude and turn angle of (x,y).
module cfc_vec #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [SW-1:0]                side_i,
  input  logic signed [cfc_pkg::CW-1:0] x_i,
  input  logic signed [cfc_pkg::CW-1:0] y_i,
  output logic                         valid_o,
  output logic [SW-1:0]                side_o,
  output logic signed [cfc_pkg::CW-1:0] mag_o,
  output logic [31:0]                  ang_o
);
  import cfc_pkg::*;

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic [31:0]          a_q [STEPS+1];
  logic [SW-1:0]        s_q [STEPS+1];
  logic signed [CW-1:0] x_d [STEPS+1];
  logic signed [CW-1:0] y_d [STEPS+1];
  logic [31:0]          a_d [STEPS+1];
  logic [STEPS:0]       v_q;

  logic signed [CW+21:0] prod_q, rsum;
  logic [31:0]           a_m_q, a_r_q;
  logic [SW-1:0]         s_m_q, s_r_q;
  logic                  v_m_q, v_r_q;
  logic signed [CW-1:0]  mag_q;

  always_comb begin
    x_d[0] = x_i[CW-1] ? -x_i : x_i;
    y_d[0] = x_i[CW-1] ? -y_i : y_i;
    a_d[0] = x_i[CW-1] ? 32'h8000_0000 : 32'h0;
    for (int k = 0; k < STEPS; k++) begin
      if (!y_q[k][CW-1]) begin
        x_d[k+1] = x_q[k] + (y_q[k] >>> k);
        y_d[k+1] = y_q[k] - (x_q[k] >>> k);
        a_d[k+1] = a_q[k] + ATAN_TAB[k[4:0]];
      end else begin
        x_d[k+1] = x_q[k] - (y_q[k] >>> k);
        y_d[k+1] = y_q[k] + (x_q[k] >>> k);
        a_d[k+1] = a_q[k] - ATAN_TAB[k[4:0]];
      end
    end
  end

  assign rsum = prod_q + (CW+22)'(32'h0008_0000);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= STEPS; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        a_q[k] <= a_d[k];
      end
      s_q[0] <= side_i;
      for (int k = 0; k < STEPS; k++) begin
        s_q[k+1] <= s_q[k];
      end
      prod_q <= x_q[STEPS] * INV_GAIN_Q20;
      a_m_q  <= a_q[STEPS];
      s_m_q  <= s_q[STEPS];
      mag_q  <= rsum[CW+19:20];
      a_r_q  <= a_m_q;
      s_r_q  <= s_m_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      v_m_q <= 1'b0;
      v_r_q <= 1'b0;
    end else if (en_i) begin
      v_q   <= {v_q[STEPS-1:0], valid_i};
      v_m_q <= v_q[STEPS];
      v_r_q <= v_m_q;
    end
  end

  assign valid_o = v_r_q;
  assign side_o  = s_r_q;
  assign mag_o   = mag_q;
  assign ang_o   = a_r_q;

endmodule

@@ sv/cfc_rot.sv @@
// Pipelined rotation CORDIC: cos and sin of a turn angle in Q3.30.
module cfc_rot #(
  parameter int STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [31:0]                  ang_i,
  output logic signed [cfc_pkg::RW-1:0] cos_o,
  output logic signed [cfc_pkg::RW-1:0] sin_o
);
  import cfc_pkg::*;

  logic signed [RW-1:0] x_q [STEPS+1];
  logic signed [RW-1:0] y_q [STEPS+1];
  logic signed [RW-1:0] z_q [STEPS+1];
  logic signed [RW-1:0] x_d [STEPS+1];
  logic signed [RW-1:0] y_d [STEPS+1];
  logic signed [RW-1:0] z_d [STEPS+1];
  logic [STEPS:0]       f_q;
  logic                 flip;
  logic signed [RW-1:0] c1_q, s1_q, c2_q, s2_q;

  assign flip = ang_i[31] ^ ang_i[30];

  always_comb begin
    x_d[0] = INV_GAIN_Q30;
    y_d[0] = '0;
    z_d[0] = {{(RW-31){ang_i[31] ^ flip}}, ang_i[30:0]};
    for (int k = 0; k < STEPS; k++) begin
      if (!z_q[k][RW-1]) begin
        x_d[k+1] = x_q[k] - (y_q[k] >>> k);
        y_d[k+1] = y_q[k] + (x_q[k] >>> k);
        z_d[k+1] = z_q[k] - RW'(ATAN_TAB[k[4:0]]);
      end else begin
        x_d[k+1] = x_q[k] + (y_q[k] >>> k);
        y_d[k+1] = y_q[k] - (x_q[k] >>> k);
        z_d[k+1] = z_q[k] + RW'(ATAN_TAB[k[4:0]]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= STEPS; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
      end
      f_q  <= {f_q[STEPS-1:0], flip};
      c1_q <= f_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
      s1_q <= f_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
      c2_q <= c1_q;
      s2_q <= s1_q;
    end
  end

  assign cos_o = c2_q;
  assign sin_o = s2_q;

endmodule
